>>> rtl/core/fuq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first unique symbol tracker.
// No dependencies.
package fuq_pkg;

	localparam int SYM_W = 8;
	localparam int ST_W  = 2;

	localparam logic [SYM_W-1:0] NONE_MARKER_RST = 8'd35; // '#'

	// Per-symbol status codes
	localparam logic [ST_W-1:0] ST_UNSEEN   = 2'd0;
	localparam logic [ST_W-1:0] ST_LISTED   = 2'd1;
	localparam logic [ST_W-1:0] ST_REPEATED = 2'd2;

	// Write-back commands for one committed transaction
	typedef struct packed {
		logic             status_we;
		logic [ST_W-1:0]  status_data;
		logic             prev_we;
		logic [SYM_W-1:0] prev_addr;
		logic [SYM_W-1:0] prev_data;
		logic             next_we;
		logic [SYM_W-1:0] next_addr;
		logic [SYM_W-1:0] next_data;
	} list_wr_t;

endpackage

>>> rtl/core/first_unique_symbol_tracker.sv
`timescale 1ns / 1ps
// First unique symbol tracker: one byte symbol per input transaction, one
// result per transaction giving the earliest symbol seen exactly once so far.
//
// Channels: input (in_valid/in_stall, symbol) and output (out_valid/out_stall,
// first_unique, found). A transaction moves when valid is high and stall low.
// none_marker_we/none_marker write the marker given when no unique symbol
// exists (found = 0); write it only while the block is idle.
// The result comes through the read stage (RAM read data) and the output register.
// A new transaction is taken only once the read stage is empty. The first step
// reads the status, prev-link and next-link RAMs at the symbol; the second
// decides and writes all three back. The next read waits for that write-back, so the
// RAM read-modify-write loop sets how often a transaction can be taken.
// Reset: asynchronous, clears status valid bits, list head/tail/count and
// both handshakes, and sets the marker to '#'. No clearing pass is needed.
// Stall: a finished result sits in the output register; one more input
// transaction is taken and holds in the read stage until the output frees,
// then in_stall stays high.
// Depends on fuq_pkg, fuq_ram, fuq_list_ctrl.
module first_unique_symbol_tracker #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      none_marker_we,
	input  logic [fuq_pkg::SYM_W-1:0] none_marker,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fuq_pkg::SYM_W-1:0] symbol,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [fuq_pkg::SYM_W-1:0] first_unique,
	output logic                      found
);
	import fuq_pkg::*;

	localparam int AW = $clog2(ALPHABET_SIZE);

	logic             s1_valid_q;
	logic [SYM_W-1:0] sym_s1;
	logic             out_valid_q, found_q;
	logic [SYM_W-1:0] first_unique_q, marker_q;
	logic             accept, commit;
	logic [AW-1:0]    rd_addr;
	logic [ST_W-1:0]  st_rd;
	logic [SYM_W-1:0] prev_rd, next_rd, head_nxt;
	logic             nonempty_nxt;
	list_wr_t         wr;

	// one item in the read stage blocks the next: interlock on RAM write-back
	assign in_stall = s1_valid_q;
	assign accept   = in_valid && !in_stall;
	assign commit   = s1_valid_q && !(out_valid_q && out_stall);

	// keep reading the held symbol so RAM data stays put during a stall
	assign rd_addr = s1_valid_q ? sym_s1[AW-1:0] : symbol[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1 <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= NONE_MARKER_RST;
		end else if (none_marker_we) begin
			marker_q <= none_marker;
		end
	end

	fuq_ram #(.WIDTH(ST_W), .DEPTH(ALPHABET_SIZE)) u_status_ram (
		.clk   (clk),
		.we    (wr.status_we),
		.waddr (sym_s1[AW-1:0]),
		.wdata (wr.status_data),
		.raddr (rd_addr),
		.rdata (st_rd)
	);

	fuq_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_prev_ram (
		.clk   (clk),
		.we    (wr.prev_we),
		.waddr (wr.prev_addr[AW-1:0]),
		.wdata (wr.prev_data),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

	fuq_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_next_ram (
		.clk   (clk),
		.we    (wr.next_we),
		.waddr (wr.next_addr[AW-1:0]),
		.wdata (wr.next_data),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	fuq_list_ctrl #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_list_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.sym          (sym_s1),
		.st_rd        (st_rd),
		.prev_rd      (prev_rd),
		.next_rd      (next_rd),
		.wr           (wr),
		.head_nxt     (head_nxt),
		.nonempty_nxt (nonempty_nxt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			first_unique_q <= nonempty_nxt ? head_nxt : marker_q;
			found_q        <= nonempty_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_unique = first_unique_q;
	assign found        = found_q;

	// no write-back may land in the cycle a new read is launched
	a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(wr.status_we || wr.prev_we || wr.next_we))
		else $error("RAM write-back overlaps a new read");

	// an accepted transaction is held in the read stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (s1_valid_q && sym_s1 == $past(symbol)))
		else $error("accepted symbol not captured");

	// a blocked item keeps its symbol until the output frees
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && out_stall) |=> (s1_valid_q && $stable(sym_s1)))
		else $error("held transaction lost");

endmodule

>>> rtl/core/fuq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fuq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/fuq_list_ctrl.sv
`timescale 1ns / 1ps
// List control: head/tail/count registers, status valid bits and the
// read-modify-write decision for one transaction. Depends on fuq_pkg.
module fuq_list_ctrl #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    commit,
	input  logic [fuq_pkg::SYM_W-1:0] sym,
	input  logic [fuq_pkg::ST_W-1:0]  st_rd,
	input  logic [fuq_pkg::SYM_W-1:0] prev_rd,
	input  logic [fuq_pkg::SYM_W-1:0] next_rd,
	output fuq_pkg::list_wr_t         wr,
	output logic [fuq_pkg::SYM_W-1:0] head_nxt,
	output logic                      nonempty_nxt
);
	import fuq_pkg::*;

	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam int CW = $clog2(ALPHABET_SIZE + 1);

	logic [ALPHABET_SIZE-1:0] vld_q;
	logic [SYM_W-1:0]         head_q, tail_q, head_n, tail_n;
	logic [CW-1:0]            cnt_q, cnt_n;
	logic                     in_range;
	logic [ST_W-1:0]          st_eff;
	list_wr_t                 wr_c;

	assign in_range = ({1'b0, sym} < 9'(ALPHABET_SIZE));
	// unwritten status entries read as unseen
	assign st_eff = (in_range && vld_q[sym[AW-1:0]]) ? st_rd : ST_UNSEEN;

	always_comb begin
		wr_c   = '0;
		head_n = head_q;
		tail_n = tail_q;
		cnt_n  = cnt_q;
		if (in_range) begin
			case (st_eff)
				ST_UNSEEN: begin
					wr_c.status_we   = 1'b1;
					wr_c.status_data = ST_LISTED;
					if (cnt_q == '0) begin
						head_n = sym;
					end else begin
						wr_c.next_we   = 1'b1;
						wr_c.next_addr = tail_q;
						wr_c.next_data = sym;
						wr_c.prev_we   = 1'b1;
						wr_c.prev_addr = sym;
						wr_c.prev_data = tail_q;
					end
					tail_n = sym;
					cnt_n  = CW'(cnt_q + 1'b1);
				end
				ST_LISTED: begin
					wr_c.status_we   = 1'b1;
					wr_c.status_data = ST_REPEATED;
					if (sym == head_q) begin
						head_n = next_rd;
					end else begin
						wr_c.next_we   = 1'b1;
						wr_c.next_addr = prev_rd;
						wr_c.next_data = next_rd;
					end
					if (sym == tail_q) begin
						tail_n = prev_rd;
					end else begin
						wr_c.prev_we   = 1'b1;
						wr_c.prev_addr = next_rd;
						wr_c.prev_data = prev_rd;
					end
					if (cnt_q != '0) begin
						cnt_n = CW'(cnt_q - 1'b1);
					end
					if (cnt_n == '0) begin
						head_n = '0;
						tail_n = '0;
					end
				end
				default: begin
					// repeated (or unused code): no change
				end
			endcase
		end
	end

	assign wr           = commit ? wr_c : '0;
	assign head_nxt     = head_n;
	assign nonempty_nxt = (cnt_n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (commit) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
			if (wr_c.status_we) begin
				vld_q[sym[AW-1:0]] <= 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for first_unique_symbol_tracker: a directed opener, then random phases.
// Results are checked against an in-bench model of the status store and order list.
// Depends on fuq_pkg and the tracker RTL only.
module tb_top;
	import fuq_pkg::*;

	localparam int ALPHA_SIZE = 256;
	localparam int RANDOM_ITEMS = 1700;
	// Watchdog limit; a run that reaches it reports a failure.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 4;   // extra idle margin after every result is back

	typedef enum int {PH_BUILD, PH_DRAIN, PH_MIX} phase_kind_t;

	// One result transaction as the monitor sees it
	typedef struct packed {
		logic [SYM_W-1:0] first_unique;
		logic             found;
	} answer_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             none_marker_we = 1'b0;
	logic [SYM_W-1:0] none_marker = NONE_MARKER_RST;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [SYM_W-1:0] symbol = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [SYM_W-1:0] first_unique;
	logic             found;

	first_unique_symbol_tracker #(
		.ALPHABET_SIZE(ALPHA_SIZE)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.none_marker_we(none_marker_we),
		.none_marker   (none_marker),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.symbol        (symbol),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_unique  (first_unique),
		.found         (found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Tracker model: per-symbol status plus a doubly linked order list.
	// Links are only read for symbols that are currently listed, and those
	// were written on append, so stale entries never matter.
	// ------------------------------------------------------------------
	logic [ST_W-1:0]  sym_status [1 << SYM_W];
	logic [SYM_W-1:0] prev_sym   [1 << SYM_W];
	logic [SYM_W-1:0] next_sym   [1 << SYM_W];
	logic [SYM_W-1:0] order_head = '0;
	logic [SYM_W-1:0] order_tail = '0;
	logic [8:0]       order_len  = '0;
	logic [SYM_W-1:0] marker_cfg = NONE_MARKER_RST;

	initial begin
		for (int i = 0; i < (1 << SYM_W); i++)
			sym_status[i] = ST_UNSEEN;
	end

	function automatic answer_t track_symbol(input logic [SYM_W-1:0] s);
		answer_t          res;
		logic [SYM_W-1:0] prv;
		logic [SYM_W-1:0] nxt;
		// symbols past the alphabet leave the state alone
		if (int'(s) < ALPHA_SIZE) begin
			case (sym_status[s])
				ST_UNSEEN: begin
					// first sighting: append at the tail
					if (order_len == 0)
						order_head = s;
					else begin
						next_sym[order_tail] = s;
						prev_sym[s] = order_tail;
					end
					order_tail = s;
					order_len = order_len + 1'b1;
					sym_status[s] = ST_LISTED;
				end
				ST_LISTED: begin
					// second sighting: unlink, taking care of head, tail and only node
					prv = prev_sym[s];
					nxt = next_sym[s];
					if (s == order_head)
						order_head = nxt;
					else
						next_sym[prv] = nxt;
					if (s == order_tail)
						order_tail = prv;
					else
						prev_sym[nxt] = prv;
					if (order_len != 0)
						order_len = order_len - 1'b1;
					if (order_len == 0) begin
						order_head = '0;
						order_tail = '0;
					end
					sym_status[s] = ST_REPEATED;
				end
				default: ;   // repeated (or the unused code): nothing changes
			endcase
		end
		if (order_len != 0) begin
			res.first_unique = order_head;
			res.found = 1'b1;
		end else begin
			res.first_unique = marker_cfg;
			res.found = 1'b0;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	logic [SYM_W-1:0] symbol_q[$];      // symbols waiting to be sent
	answer_t          answer_q[$];      // predicted results, oldest first
	int               fail_count = 0;
	bit               quiet_in = 1'b0;  // phases with no sender gaps
	bit               quiet_out = 1'b0; // phases with no receiver stalls
	int               in_gap = 0;
	int               stall_left = 0;
	int               cycle_count = 0;
	answer_t          oldest;

	// Mostly short idles, the odd long one.
	function automatic int draw_idle(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Driver: input transaction moves when in_valid && !in_stall. A stalled
	// symbol is held; the model advances on every accepted transaction.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				answer_q.push_back(track_symbol(symbol));
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (symbol_q.size() != 0) begin
				in_valid <= 1'b1;
				symbol <= symbol_q.pop_front();
				in_gap <= draw_idle(quiet_in);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transaction with the oldest prediction,
	// and throw random stalls at the output.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$error("unexpected result: first_unique=%0h found=%0b",
						first_unique, found);
					fail_count++;
				end else begin
					oldest = answer_q.pop_front();
					if (first_unique !== oldest.first_unique) begin
						$error("first_unique: expected %0h, got %0h",
							oldest.first_unique, first_unique);
						fail_count++;
					end
					if (found !== oldest.found) begin
						$error("found: expected %0b, got %0b", oldest.found, found);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= draw_idle(quiet_out);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus. The stream can never be restarted (reset is only at start),
	// and each symbol gets just one append and one unlink for the whole run.
	// So fresh symbols are rationed across phases, and most of the filler
	// is third-or-later sightings, which still check the current head.
	// ------------------------------------------------------------------
	logic [SYM_W-1:0] fresh_syms[$];   // never sent
	logic [SYM_W-1:0] listed_syms[$];  // sent once, in list order
	logic [SYM_W-1:0] retired_syms[$]; // sent twice or more
	int               random_items = 0;

	// Second sighting of a listed symbol; head and tail get picked often.
	function automatic logic [SYM_W-1:0] retire_listed();
		int               idx;
		int               pick;
		logic [SYM_W-1:0] s;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			idx = 0;
		else if (pick == 1)
			idx = listed_syms.size() - 1;
		else
			idx = $urandom_range(0, listed_syms.size() - 1);
		s = listed_syms[idx];
		listed_syms.delete(idx);
		retired_syms.push_back(s);
		return s;
	endfunction

	task automatic gen_phase(input phase_kind_t kind, input int len);
		int               r;
		int               idx;
		int               fresh_pct;
		int               second_pct;
		logic [SYM_W-1:0] s;
		case (kind)
			PH_BUILD: begin fresh_pct = 45; second_pct = 10; end
			PH_DRAIN: begin fresh_pct = 5;  second_pct = 45; end
			default:  begin fresh_pct = 15; second_pct = 20; end
		endcase
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < fresh_pct && fresh_syms.size() != 0) begin
				idx = $urandom_range(0, fresh_syms.size() - 1);
				s = fresh_syms[idx];
				fresh_syms.delete(idx);
				listed_syms.push_back(s);
			end else if (r < fresh_pct + second_pct && listed_syms.size() != 0) begin
				s = retire_listed();
			end else begin
				s = retired_syms[$urandom_range(0, retired_syms.size() - 1)];
			end
			symbol_q.push_back(s);
		end
		// a drain phase always empties the list so the marker shows
		if (kind == PH_DRAIN)
			while (listed_syms.size() != 0) begin
				symbol_q.push_back(retire_listed());
				len++;
			end
		random_items += len;
	endtask

	// Wait until every sent transaction has its result back, plus a margin.
	task automatic wait_idle();
		while (symbol_q.size() != 0 || in_valid || answer_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Only called while idle, so the model can take the value right away.
	task automatic write_marker(input logic [SYM_W-1:0] v);
		@(posedge clk);
		none_marker_we <= 1'b1;
		none_marker <= v;
		@(posedge clk);
		none_marker_we <= 1'b0;
		marker_cfg = v;
		@(negedge clk);
	endtask

	initial begin
		phase_kind_t      kind;
		int               len;
		int               r;
		logic [SYM_W-1:0] m;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset marker: only node twice and a third time, then
		// head removal, tail removal, middle removal, down to empty.
		symbol_q = {8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'h80,
			8'h02, 8'h03, 8'h02, 8'h01, 8'h03};
		wait_idle();
		// marker at its low extreme, empty list reached by unlinking the tail
		write_marker(8'h00);
		symbol_q = {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h01};
		wait_idle();
		// marker at its high extreme
		write_marker(8'hFF);
		symbol_q = {8'h7F, 8'h7F, 8'hFE, 8'hFE};
		wait_idle();

		for (int v = 0; v < (1 << SYM_W); v++) begin
			if (sym_status[v] == ST_UNSEEN)
				fresh_syms.push_back(SYM_W'(v));
			else
				retired_syms.push_back(SYM_W'(v));
		end

		while (random_items < RANDOM_ITEMS) begin
			quiet_in = ($urandom_range(0, 4) == 0);
			quiet_out = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 3);
			kind = (r >= 2) ? PH_MIX : phase_kind_t'(r);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
				: $urandom_range(8, 50);
			gen_phase(kind, len);
			// the sender holds off here until every result is back
			wait_idle();
			if ($urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 3);
				m = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : SYM_W'($urandom_range(0, 255));
				write_marker(m);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/fuq_pkg.sv
rtl/core/fuq_ram.sv
rtl/core/fuq_list_ctrl.sv
rtl/core/first_unique_symbol_tracker.sv
tb/sv/tb_top.sv
